// ===== hdl/heightmap_normal_generator_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef HEIGHTMAP_NORMAL_GENERATOR_MACROS_SVH
`define HEIGHTMAP_NORMAL_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define HMN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HMN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HMN_ASSERT(lbl, clk, rst_n, prop, msg)
`define HMN_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/hmn_pkg.sv =====
`default_nettype none
package hmn_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int FRAC_BITS_DEF = 14;

    localparam logic [10:0] WIDTH_RESET   = 11'd512;
    localparam logic [15:0] ROWS_RESET    = 16'd512;
    localparam logic [7:0]  DIVISOR_RESET = 8'd30;

    // register index = paddr[3:2]
    localparam logic [1:0] REG_WIDTH   = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_DIVISOR = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QPW    = 2;
    localparam int QCW    = 3;

    // one input sample with its neighborhood, handed from front to back
    typedef struct packed {
        logic [7:0]  h;
        logic [7:0]  prev;
        logic [7:0]  prev2;
        logic [7:0]  mid0;
        logic [7:0]  mid1;
        logic [7:0]  mid2;
        logic [7:0]  up0;
        logic [7:0]  up1;
        logic [9:0]  col;
        logic [15:0] row;
        logic        c_ge1;
        logic        c_ge2;
        logic        r_ge1;
        logic        r_ge2;
        logic        row_end;
        logic        final_row;
    } t_job;

endpackage
`default_nettype wire

// ===== hdl/hmn_ram.sv =====
`default_nettype none
module hmn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // read-first on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/hmn_fifo.sv =====
`default_nettype none
`include "heightmap_normal_generator_macros.svh"
module hmn_fifo (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire hmn_pkg::t_job         i_data,
    input  wire logic                  i_pop,
    output hmn_pkg::t_job              o_head,
    output logic                       o_empty,
    output logic [hmn_pkg::QCW-1:0]    o_count
);
    hmn_pkg::t_job r_mem [hmn_pkg::QDEPTH];
    logic [hmn_pkg::QPW-1:0] r_wp, r_rp;
    logic [hmn_pkg::QCW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

    `HMN_ASSERT(a_no_overflow, i_clk, i_rst_n,
        i_push |-> (r_cnt < hmn_pkg::QCW'(hmn_pkg::QDEPTH)) || i_pop, "queue overflow")
    `HMN_ASSERT(a_no_underflow, i_clk, i_rst_n,
        i_pop |-> (r_cnt != '0), "pop from empty queue")
endmodule
`default_nettype wire

// ===== hdl/hmn_front.sv =====
`default_nettype none
module hmn_front #(
    parameter int MAX_WIDTH = hmn_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic [7:0]             i_height_sample,
    output logic                        o_stall,
    input  wire logic [10:0]            i_width,
    input  wire logic [15:0]            i_rows,
    input  wire logic [hmn_pkg::QCW-1:0] i_q_count,
    output logic                        o_push,
    output hmn_pkg::t_job               o_job
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > 11) ? CW + 1 : 11;

    logic [CW-1:0] r_col;
    logic [15:0]   r_row;
    logic          r_sel;
    logic          r_s1_valid;
    logic [7:0]    r_s1_h;
    logic [CW-1:0] r_s1_col;
    logic [15:0]   r_s1_row;
    logic          r_s1_sel, r_s1_ge1, r_s1_ge2, r_s1_rge1, r_s1_rge2, r_s1_end, r_s1_fin;
    logic [7:0]    r_prev, r_prev2, r_mid1, r_mid2, r_up1;

    logic          w_acc;
    logic [WW-1:0] w_w, w_last;
    logic [15:0]   w_rows_eff;
    logic          w_end, w_fin;
    logic [7:0]    w_qa, w_qb, w_mid0, w_up0;

    assign o_stall = (({1'b0, i_q_count} + {{hmn_pkg::QCW{1'b0}}, r_s1_valid})
                      >= (hmn_pkg::QCW + 1)'(hmn_pkg::QDEPTH));
    assign w_acc = i_valid && !o_stall;

    always_comb begin
        w_w = WW'(i_width);
        if (w_w < WW'(2))              w_w = WW'(2);
        else if (w_w > WW'(MAX_WIDTH)) w_w = WW'(MAX_WIDTH);
        w_last     = w_w - 1'b1;
        w_rows_eff = (i_rows < 16'd2) ? 16'd2 : i_rows;
        w_end      = WW'(r_col) >= w_last;
        w_fin      = r_row >= (w_rows_eff - 1'b1);
    end

    // bank r_sel holds the upper line, the other one the middle line
    hmn_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (w_acc && !r_sel),
        .i_waddr (r_col),
        .i_wdata (i_height_sample),
        .i_re    (w_acc),
        .i_raddr (r_col),
        .o_rdata (w_qa)
    );
    hmn_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (w_acc && r_sel),
        .i_waddr (r_col),
        .i_wdata (i_height_sample),
        .i_re    (w_acc),
        .i_raddr (r_col),
        .o_rdata (w_qb)
    );

    assign w_mid0 = r_s1_sel ? w_qa : w_qb;
    assign w_up0  = r_s1_sel ? w_qb : w_qa;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_sel      <= 1'b0;
            r_s1_valid <= 1'b0;
            r_prev     <= '0;
        end else begin
            r_s1_valid <= w_acc;
            if (w_acc) begin
                if (w_end) begin
                    r_col <= '0;
                    r_row <= w_fin ? 16'd0 : r_row + 1'b1;
                    r_sel <= !r_sel;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (r_s1_valid) begin
                r_prev <= r_s1_h;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_h    <= i_height_sample;
            r_s1_col  <= r_col;
            r_s1_row  <= r_row;
            r_s1_sel  <= r_sel;
            r_s1_ge1  <= r_col != '0;
            r_s1_ge2  <= r_col > CW'(1);
            r_s1_rge1 <= r_row != '0;
            r_s1_rge2 <= r_row > 16'd1;
            r_s1_end  <= w_end;
            r_s1_fin  <= w_fin;
        end
        if (r_s1_valid) begin
            r_prev2 <= r_prev;
            r_mid1  <= w_mid0;
            r_mid2  <= r_mid1;
            r_up1   <= w_up0;
        end
    end

    always_comb begin
        o_job.h         = r_s1_h;
        o_job.prev      = r_prev;
        o_job.prev2     = r_prev2;
        o_job.mid0      = w_mid0;
        o_job.mid1      = r_mid1;
        o_job.mid2      = r_mid2;
        o_job.up0       = w_up0;
        o_job.up1       = r_up1;
        o_job.col       = 10'(r_s1_col);
        o_job.row       = r_s1_row;
        o_job.c_ge1     = r_s1_ge1;
        o_job.c_ge2     = r_s1_ge2;
        o_job.r_ge1     = r_s1_rge1;
        o_job.r_ge2     = r_s1_rge2;
        o_job.row_end   = r_s1_end;
        o_job.final_row = r_s1_fin;
    end

    // samples that produce no normal only update the window
    assign o_push = r_s1_valid && r_s1_rge1 && (r_s1_ge1 || r_s1_end);
endmodule
`default_nettype wire

// ===== hdl/hmn_back.sv =====
`default_nettype none
`include "heightmap_normal_generator_macros.svh"
module hmn_back #(
    parameter int FRAC_BITS = hmn_pkg::FRAC_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire hmn_pkg::t_job i_job,
    input  wire logic          i_empty,
    output logic               o_pop,
    input  wire logic [7:0]    i_divisor,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [15:0]        o_normal_x,
    output logic [15:0]        o_normal_y,
    output logic [15:0]        o_normal_z,
    output logic [9:0]         o_pixel_column,
    output logic [15:0]        o_pixel_row,
    output logic               o_last_of_run
);
    localparam int QW = FRAC_BITS + 1;
    localparam int TW = FRAC_BITS + 2;
    localparam int RW = 2 * FRAC_BITS + 22;
    localparam int PW = 2 * TW + 21;
    localparam int BW = $clog2(FRAC_BITS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_RHS  = 3'd3;
    localparam logic [2:0] S_MUL1 = 3'd4;
    localparam logic [2:0] S_MUL2 = 3'd5;
    localparam logic [2:0] S_CMP  = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    localparam logic [QW-1:0] LIM = {1'b1, {FRAC_BITS{1'b0}}};

    logic [2:0]      r_state;
    hmn_pkg::t_job   r_job;
    logic [3:0]      r_en;
    logic [1:0]      r_comp;
    logic [9:0]      r_mag_x, r_mag_y, r_mag_z;
    logic            r_neg_x, r_neg_z;
    logic [19:0]     r_x2, r_y2, r_z2;
    logic [20:0]     r_sq;
    logic [RW-1:0]   r_rhs;
    logic [QW-1:0]   r_q;
    logic [BW-1:0]   r_bit;
    logic [2*TW-1:0] r_t2;
    logic            r_ok;
    logic [PW-1:0]   r_prod;
    logic [15:0]     r_nx, r_ny, r_nz;

    logic [1:0]    w_k;
    logic [7:0]    w_hl, w_hr, w_hu, w_hd, w_dv;
    logic [9:0]    w_col;
    logic [15:0]   w_row;
    logic [8:0]    w_dx, w_dz;
    logic [9:0]    w_mag;
    logic          w_neg;
    logic [19:0]   w_mag2;
    logic [QW-1:0] w_cand, w_qn;
    logic [TW-1:0] w_t;
    logic [QW:0]   w_sv;
    logic [15:0]   w_res;
    logic [3:0]    w_en_left;

    // current emission is the lowest pending one
    always_comb begin
        if (r_en[0])      w_k = 2'd0;
        else if (r_en[1]) w_k = 2'd1;
        else if (r_en[2]) w_k = 2'd2;
        else              w_k = 2'd3;
        w_en_left = r_en & ~(4'd1 << w_k);
    end

    always_comb begin
        w_col = r_job.col;
        w_row = r_job.row;
        case (w_k)
            2'd0: begin
                w_hl = r_job.c_ge2 ? r_job.mid2 : r_job.mid1;
                w_hr = r_job.mid0;
                w_hu = r_job.r_ge2 ? r_job.up1 : r_job.mid1;
                w_hd = r_job.prev;
                w_col = r_job.col - 1'b1;
                w_row = r_job.row - 1'b1;
            end
            2'd1: begin
                w_hl = r_job.c_ge2 ? r_job.prev2 : r_job.prev;
                w_hr = r_job.h;
                w_hu = r_job.mid1;
                w_hd = r_job.prev;
                w_col = r_job.col - 1'b1;
            end
            2'd2: begin
                w_hl = r_job.c_ge1 ? r_job.mid1 : r_job.mid0;
                w_hr = r_job.mid0;
                w_hu = r_job.r_ge2 ? r_job.up0 : r_job.mid0;
                w_hd = r_job.h;
                w_row = r_job.row - 1'b1;
            end
            default: begin
                w_hl = r_job.c_ge1 ? r_job.prev : r_job.h;
                w_hr = r_job.h;
                w_hu = r_job.mid0;
                w_hd = r_job.h;
            end
        endcase
        w_dx = {1'b0, w_hr} - {1'b0, w_hl};
        w_dz = {1'b0, w_hd} - {1'b0, w_hu};
        w_dv = (i_divisor == 8'd0) ? 8'd1 : i_divisor;
    end

    always_comb begin
        case (r_comp)
            2'd0:    begin w_mag = r_mag_x; w_neg = r_neg_x; end
            2'd1:    begin w_mag = r_mag_y; w_neg = 1'b1;    end
            default: begin w_mag = r_mag_z; w_neg = r_neg_z; end
        endcase
        w_mag2 = {10'd0, w_mag} * {10'd0, w_mag};
        w_cand = r_q | (QW'(1) << r_bit);
        w_t    = {1'b0, w_cand} + {1'b0, w_cand} - 1'b1;
        w_qn   = (r_ok && ({3'd0, r_rhs} >= r_prod)) ? w_cand : r_q;
        w_sv   = w_neg ? ((QW + 1)'(0) - {1'b0, w_qn}) : {1'b0, w_qn};
        w_res  = 16'($signed(w_sv));
    end

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && (!o_valid || !i_stall)) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (!i_empty) r_state <= S_SQ;
                S_SQ:   r_state <= S_SUM;
                S_SUM:  r_state <= S_RHS;
                S_RHS:  r_state <= S_MUL1;
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_CMP;
                S_CMP: begin
                    if (r_bit != '0)       r_state <= S_MUL1;
                    else if (r_comp == 2'd2) r_state <= S_EMIT;
                    else                   r_state <= S_RHS;
                end
                S_EMIT: begin
                    if (!o_valid || !i_stall) begin
                        r_state <= (w_en_left != '0) ? S_SQ : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job <= i_job;
                r_en[0] <= i_job.c_ge1 && i_job.r_ge1;
                r_en[1] <= i_job.c_ge1 && i_job.r_ge1 && i_job.final_row;
                r_en[2] <= i_job.row_end && i_job.r_ge1;
                r_en[3] <= i_job.row_end && i_job.r_ge1 && i_job.final_row;
            end
            S_SQ: begin
                r_neg_x <= w_dx[8];
                r_neg_z <= w_dz[8];
                r_mag_x <= {1'b0, (w_dx[8] ? 8'(-w_dx) : w_dx[7:0]), 1'b0};
                r_mag_z <= {1'b0, (w_dz[8] ? 8'(-w_dz) : w_dz[7:0]), 1'b0};
                r_mag_y <= {w_dv, 2'b00};
                r_x2 <= {11'd0, (w_dx[8] ? 8'(-w_dx) : w_dx[7:0]), 1'b0}
                      * {11'd0, (w_dx[8] ? 8'(-w_dx) : w_dx[7:0]), 1'b0};
                r_z2 <= {11'd0, (w_dz[8] ? 8'(-w_dz) : w_dz[7:0]), 1'b0}
                      * {11'd0, (w_dz[8] ? 8'(-w_dz) : w_dz[7:0]), 1'b0};
                r_y2 <= {10'd0, w_dv, 2'b00} * {10'd0, w_dv, 2'b00};
            end
            S_SUM: begin
                r_sq   <= {1'b0, r_x2} + {1'b0, r_y2} + {1'b0, r_z2};
                r_comp <= 2'd0;
            end
            S_RHS: begin
                r_rhs <= RW'(w_mag2) << (2 * FRAC_BITS + 2);
                r_q   <= '0;
                r_bit <= BW'(FRAC_BITS);
            end
            S_MUL1: begin
                r_t2 <= {{TW{1'b0}}, w_t} * {{TW{1'b0}}, w_t};
                r_ok <= w_cand <= LIM;
            end
            S_MUL2: begin
                r_prod <= {21'd0, r_t2} * {{(2 * TW){1'b0}}, r_sq};
            end
            S_CMP: begin
                r_q <= w_qn;
                if (r_bit != '0) begin
                    r_bit <= r_bit - 1'b1;
                end else begin
                    r_comp <= r_comp + 1'b1;
                    case (r_comp)
                        2'd0:    r_nx <= w_res;
                        2'd1:    r_ny <= w_res;
                        default: r_nz <= w_res;
                    endcase
                end
            end
            S_EMIT: begin
                if (!o_valid || !i_stall) begin
                    o_normal_x     <= r_nx;
                    o_normal_y     <= r_ny;
                    o_normal_z     <= r_nz;
                    o_pixel_column <= w_col;
                    o_pixel_row    <= w_row;
                    o_last_of_run  <= (w_en_left == '0);
                    r_en           <= w_en_left;
                end
            end
            default: ;
        endcase
    end

    `HMN_ASSERT(a_emit_source, i_clk, i_rst_n,
        $rose(o_valid) |-> $past(r_state) == S_EMIT, "beat raised outside emit")
    `HMN_ASSERT_ALWAYS(a_emit_pending, i_clk,
        (i_rst_n && r_state == S_EMIT) |-> (r_en != '0), "emit with nothing pending")
endmodule
`default_nettype wire

// ===== hdl/heightmap_normal_generator.sv =====
// Channel  Handshake              Payload
// in       i_valid / o_stall      i_height_sample
// out      o_valid / i_stall      o_normal_x/y/z, o_pixel_column, o_pixel_row, o_last_of_run
// cfg      psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// A sample is taken when i_valid is high and o_stall low; the queue takes up to four
// samples ahead of the back end. Each normal goes through the one shared bit-serial
// normalizer, one component and one result bit at a time (multiply, multiply, compare).
// A sample yields up to four normals; the input stalls when the queue fills.
// Reset (synchronous, active low) clears counters, queue and handshakes; line buffers hold
// garbage until each row is written.
`default_nettype none
module heightmap_normal_generator #(
    parameter int MAX_WIDTH = hmn_pkg::MAX_WIDTH_DEF,
    parameter int FRAC_BITS = hmn_pkg::FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_height_sample,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_normal_x,
    output logic [15:0]      o_normal_y,
    output logic [15:0]      o_normal_z,
    output logic [9:0]       o_pixel_column,
    output logic [15:0]      o_pixel_row,
    output logic             o_last_of_run,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [10:0] r_width;
    logic [15:0] r_rows;
    logic [7:0]  r_divisor;

    logic                    w_push, w_pop, w_empty;
    logic [hmn_pkg::QCW-1:0] w_count;
    hmn_pkg::t_job           w_job_in, w_job_head;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= hmn_pkg::WIDTH_RESET;
            r_rows    <= hmn_pkg::ROWS_RESET;
            r_divisor <= hmn_pkg::DIVISOR_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                hmn_pkg::REG_WIDTH:   r_width   <= pwdata[10:0];
                hmn_pkg::REG_ROWS:    r_rows    <= pwdata[15:0];
                hmn_pkg::REG_DIVISOR: r_divisor <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            hmn_pkg::REG_WIDTH:   prdata = {21'd0, r_width};
            hmn_pkg::REG_ROWS:    prdata = {16'd0, r_rows};
            hmn_pkg::REG_DIVISOR: prdata = {24'd0, r_divisor};
            default:              prdata = '0;
        endcase
    end

    hmn_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_height_sample (i_height_sample),
        .o_stall         (o_stall),
        .i_width         (r_width),
        .i_rows          (r_rows),
        .i_q_count       (w_count),
        .o_push          (w_push),
        .o_job           (w_job_in)
    );

    hmn_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_head  (w_job_head),
        .o_empty (w_empty),
        .o_count (w_count)
    );

    hmn_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (w_job_head),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .i_divisor      (r_divisor),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_normal_x     (o_normal_x),
        .o_normal_y     (o_normal_y),
        .o_normal_z     (o_normal_z),
        .o_pixel_column (o_pixel_column),
        .o_pixel_row    (o_pixel_row),
        .o_last_of_run  (o_last_of_run)
    );
endmodule
`default_nettype wire

// ===== tb/heightmap_normal_generator_test.sv =====
`default_nettype none
module heightmap_normal_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = hmn_pkg::FRAC_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 700;
    localparam logic [15:0] UNIT_DOWN = 16'hC000;   // -1.0 in Q1.14

    typedef struct {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic [9:0]  col;
        logic [15:0] row;
        logic        last;
    } normal_t;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        int          value;
        bit          flat;      // typed-in result: straight-down normal
    } step_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_height_sample;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_normal_x, o_normal_y, o_normal_z;
    logic [9:0]  o_pixel_column;
    logic [15:0] o_pixel_row;
    logic        o_last_of_run;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    heightmap_normal_generator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_height_sample(i_height_sample),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_pixel_column(o_pixel_column), .o_pixel_row(o_pixel_row),
        .o_last_of_run(o_last_of_run),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    // shadow of the block: line buffers, counters, registers
    logic [7:0]  upper_buf [hmn_pkg::MAX_WIDTH_DEF];
    logic [7:0]  middle_buf [hmn_pkg::MAX_WIDTH_DEF];
    int unsigned cur_col = 0, cur_row = 0;
    logic [7:0]  last_sample = '0;
    logic [10:0] width_reg = hmn_pkg::WIDTH_RESET;
    logic [15:0] rows_reg = hmn_pkg::ROWS_RESET;
    logic [7:0]  div_reg = hmn_pkg::DIVISOR_RESET;

    normal_t pending_normals[$];
    int errors = 0;
    int samples_sent = 0;
    int normals_seen = 0;
    int images_done = 0;
    int idle_cycles = 0;
    bit hold_req = 0;
    bit hold_done = 0;
    int burst_left = 0;

    function automatic logic [15:0] unit_component(int v, longint unsigned sq);
        longint unsigned mag, rhs, q, cand, t;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        rhs = (4 * mag * mag) << (2 * FRAC);
        q = 0;
        for (int b = FRAC; b >= 0; b--) begin
            cand = q | (64'd1 << b);
            if (cand <= (64'd1 << FRAC)) begin
                t = 2 * cand - 1;
                if (t * t * sq <= rhs)
                    q = cand;
            end
        end
        if (v < 0)
            q = -q;
        return q[15:0];
    endfunction

    function automatic normal_t make_normal(int hl, int hr, int hu, int hd, int dv,
                                            int unsigned col, int unsigned row);
        normal_t n;
        int x, y, z;
        longint unsigned sq;
        x = 2 * (hr - hl);
        y = -4 * dv;
        z = 2 * (hd - hu);
        sq = longint'(x * x) + longint'(y * y) + longint'(z * z);
        n.nx = unit_component(x, sq);
        n.ny = unit_component(y, sq);
        n.nz = unit_component(z, sq);
        n.col = col[9:0];
        n.row = row[15:0];
        n.last = 1'b0;
        return n;
    endfunction

    // push the normals that one height sample releases
    function automatic void predict_normals(logic [7:0] h, bit flat);
        normal_t outs[$];
        int unsigned w, nrows, dv, c, r, p;
        int hc, hl, hu;
        bit row_end, final_row;
        logic [7:0] t;
        w = (width_reg < 2) ? 2 : ((width_reg > hmn_pkg::MAX_WIDTH_DEF)
                                   ? hmn_pkg::MAX_WIDTH_DEF : width_reg);
        nrows = (rows_reg < 2) ? 2 : rows_reg;
        dv = (div_reg == 0) ? 1 : div_reg;
        c = (cur_col > hmn_pkg::MAX_WIDTH_DEF - 1) ? hmn_pkg::MAX_WIDTH_DEF - 1 : cur_col;
        r = cur_row;
        row_end = c >= w - 1;
        final_row = r >= nrows - 1;
        if (c >= 1 && r >= 1) begin
            p = c - 1;
            hc = middle_buf[p];
            hl = (p >= 1) ? middle_buf[p-1] : hc;
            hu = (r >= 2) ? upper_buf[p] : hc;
            outs.push_back(make_normal(hl, middle_buf[c], hu, last_sample, dv, p, r - 1));
            if (final_row) begin
                hl = (p >= 1) ? upper_buf[p-1] : last_sample;
                outs.push_back(make_normal(hl, h, middle_buf[p], last_sample, dv, p, r));
            end
        end
        if (c >= 1)
            upper_buf[c-1] = last_sample;
        if (row_end && r >= 1) begin
            hc = middle_buf[c];
            hl = (c >= 1) ? middle_buf[c-1] : hc;
            hu = (r >= 2) ? upper_buf[c] : hc;
            outs.push_back(make_normal(hl, hc, hu, h, dv, c, r - 1));
            if (final_row) begin
                hl = (c >= 1) ? last_sample : h;
                outs.push_back(make_normal(hl, h, middle_buf[c], h, dv, c, r));
            end
        end
        if (row_end) begin
            upper_buf[c] = h;
            for (int i = 0; i < hmn_pkg::MAX_WIDTH_DEF; i++) begin
                t = upper_buf[i];
                upper_buf[i] = middle_buf[i];
                middle_buf[i] = t;
            end
            cur_col = 0;
            cur_row = final_row ? 0 : ((r + 1) & 16'hFFFF);
            if (final_row)
                images_done++;
        end else begin
            cur_col = c + 1;
        end
        last_sample = h;
        if (outs.size() > 0)
            outs[outs.size()-1].last = 1'b1;
        foreach (outs[i]) begin
            if (flat) begin
                outs[i].nx = '0;
                outs[i].ny = UNIT_DOWN;
                outs[i].nz = '0;
            end
            pending_normals.push_back(outs[i]);
        end
    endfunction

    task automatic send_sample(logic [7:0] h, bit flat);
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        predict_normals(h, flat);
        i_valid <= 1'b1;
        i_height_sample <= h;
        do
            @(posedge i_clk);
        while (o_stall);
        samples_sent++;
    endtask

    // drain, let the block finish any sample that made no normal, then go quiet
    task automatic settle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_normals.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            hmn_pkg::REG_WIDTH:   width_reg = value[10:0];
            hmn_pkg::REG_ROWS:    rows_reg = value[15:0];
            hmn_pkg::REG_DIVISOR: div_reg = value[7:0];
            default: ;
        endcase
    endtask

    function automatic logic [7:0] pick_height(int style, int unsigned n);
        case (style)
            0: return 8'($urandom_range(0, 255));
            1: return 8'(n * 3 + $urandom_range(0, 4));
            default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    task automatic run_image();
        int style;
        int unsigned n;
        style = $urandom_range(0, 2);
        n = 0;
        do begin
            send_sample(pick_height(style, n), 1'b0);
            n++;
        end while (cur_col != 0 || cur_row != 0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            normals_seen++;
            if (pending_normals.size() == 0) begin
                $error("unexpected normal col %0d row %0d", o_pixel_column, o_pixel_row);
                errors++;
            end else begin
                normal_t e;
                e = pending_normals.pop_front();
                if (o_normal_x !== e.nx) begin
                    $error("normal_x exp %h got %h", e.nx, o_normal_x); errors++;
                end
                if (o_normal_y !== e.ny) begin
                    $error("normal_y exp %h got %h", e.ny, o_normal_y); errors++;
                end
                if (o_normal_z !== e.nz) begin
                    $error("normal_z exp %h got %h", e.nz, o_normal_z); errors++;
                end
                if (o_pixel_column !== e.col) begin
                    $error("pixel_column exp %0d got %0d", e.col, o_pixel_column); errors++;
                end
                if (o_pixel_row !== e.row) begin
                    $error("pixel_row exp %0d got %0d", e.row, o_pixel_row); errors++;
                end
                if (o_last_of_run !== e.last) begin
                    $error("last_of_run exp %b got %b", e.last, o_last_of_run); errors++;
                end
            end
        end
    end

    // receiver: changing stall modes, plus one long hold-off on request
    int stall_mode = 0, mode_left = 0, hold_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left = 2500;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 400);
            end
            mode_left--;
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    step_t directed[$] = '{
        '{1, hmn_pkg::REG_WIDTH, 2, 0}, '{1, hmn_pkg::REG_ROWS, 2, 0},
        '{1, hmn_pkg::REG_DIVISOR, 0, 0},
        '{0, 0, 7, 1}, '{0, 0, 7, 1}, '{0, 0, 7, 1}, '{0, 0, 7, 1},
        '{1, hmn_pkg::REG_DIVISOR, 255, 0},
        '{0, 0, 0, 0}, '{0, 0, 255, 0}, '{0, 0, 255, 0}, '{0, 0, 0, 0},
        '{1, hmn_pkg::REG_WIDTH, 1, 0}, '{1, hmn_pkg::REG_ROWS, 0, 0},
        '{1, hmn_pkg::REG_DIVISOR, 1, 0},
        '{0, 0, 255, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 255, 0},
        '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 255, 0}, '{0, 0, 255, 0},
        '{1, hmn_pkg::REG_WIDTH, 3, 0},
        '{0, 0, 255, 1}, '{0, 0, 255, 1}, '{0, 0, 255, 1},
        '{0, 0, 255, 1}, '{0, 0, 255, 1}, '{0, 0, 255, 1}
    };

    initial begin
        int random_start;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_height_sample = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                settle();
                write_reg(directed[i].reg_idx, directed[i].value);
            end else begin
                send_sample(8'(directed[i].value), directed[i].flat);
            end
        end

        settle();
        hold_req = 1;
        random_start = samples_sent;
        while (samples_sent - random_start < 240) begin
            write_reg(hmn_pkg::REG_WIDTH, $urandom_range(0, 9) == 0 ? $urandom_range(0, 1)
                                                                   : $urandom_range(2, 12));
            write_reg(hmn_pkg::REG_ROWS, $urandom_range(0, 6));
            write_reg(hmn_pkg::REG_DIVISOR,
                      $urandom_range(0, 4) == 0 ? 8'($urandom_range(0, 1) * 255)
                                                : $urandom_range(0, 255));
            run_image();
            settle();
        end

        // width register past the top of its range keeps the row open,
        // then a narrow setting closes it
        write_reg(hmn_pkg::REG_WIDTH, 2047);
        write_reg(hmn_pkg::REG_ROWS, 2);
        write_reg(hmn_pkg::REG_DIVISOR, 30);
        for (int i = 0; i < 6; i++)
            send_sample(8'($urandom_range(0, 255)), 1'b0);
        settle();
        write_reg(hmn_pkg::REG_WIDTH, 4);
        run_image();
        settle();

        // tallest row setting, cut short by lowering it mid-image
        write_reg(hmn_pkg::REG_WIDTH, 3);
        write_reg(hmn_pkg::REG_ROWS, 65535);
        for (int i = 0; i < 9; i++)
            send_sample(8'($urandom_range(0, 255)), 1'b0);
        settle();
        write_reg(hmn_pkg::REG_ROWS, 1);
        run_image();
        settle();

        $display("sent %0d height samples over %0d images, checked %0d normals",
                 samples_sent, images_done, normals_seen);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
